@@ src/twiddle_pid_gain_tuner_defines.svh @@
// assertion macros for the twiddle gain tuner
// used by the top level only, no other dependencies
`ifndef TWIDDLE_PID_GAIN_TUNER_DEFINES_SVH
`define TWIDDLE_PID_GAIN_TUNER_DEFINES_SVH

// condition must hold in the same cycle
`define TWP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("twiddle tuner check failed");

// condition must hold in the next cycle
`define TWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("twiddle tuner check failed");

`endif

@@ src/twp_pkg.sv @@
// shared types, register indexes and constants of the twiddle gain tuner
// no dependencies
package twp_pkg;

	localparam int NUM_GAINS = 3;
	localparam int GAIN_W    = 32;
	localparam int STEP_W    = 31;
	localparam int NUM_W     = 35;
	localparam int IDX_W     = 2;
	localparam int CFG_IDX_W = 3;

	// step scaling: (step * mul + 5) / 10
	localparam int GROW_MUL   = 11;
	localparam int SHRINK_MUL = 9;
	localparam int ROUND_ADD  = 5;

	typedef logic signed [GAIN_W-1:0] gain_t;
	typedef logic [STEP_W-1:0]        step_t;
	typedef logic [IDX_W-1:0]         gidx_t;
	typedef logic [NUM_W-1:0]         num_t;

	typedef gain_t gain_arr_t [NUM_GAINS];
	typedef step_t step_arr_t [NUM_GAINS];

	localparam gidx_t IDX_LAST = gidx_t'(NUM_GAINS - 1);

	typedef enum logic [2:0] {
		PH_ADD   = 3'b001,
		PH_PLUS  = 3'b010,
		PH_MINUS = 3'b100
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P = 3'd0,
		CFG_GAIN_I = 3'd1,
		CFG_GAIN_D = 3'd2,
		CFG_STEP_P = 3'd3,
		CFG_STEP_I = 3'd4,
		CFG_STEP_D = 3'd5,
		CFG_TOL    = 3'd6
	} cfg_reg_t;

	localparam gain_t RST_GAIN_P = -32'sd131072;
	localparam gain_t RST_GAIN_I = 32'sd0;
	localparam gain_t RST_GAIN_D = 32'sd0;
	localparam step_t RST_STEP_P = 31'd65536;
	localparam step_t RST_STEP_I = 31'd6554;
	localparam step_t RST_STEP_D = 31'd6554;
	localparam step_t RST_TOL    = 31'd66;

	typedef struct packed {
		logic  en;
		gidx_t idx;
		num_t  num;
	} scale_req_t;

	typedef struct packed {
		logic   started;
		phase_t phase;
		gidx_t  idx;
	} search_stat_t;

endpackage

@@ src/twp_search.sv @@
// search state of the tuner: gains, best error, tuned index and phase
// depends on twp_pkg
module twp_search (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  twp_pkg::gain_t       err,
	input  twp_pkg::gain_arr_t   cfg_gain,
	input  twp_pkg::step_arr_t   steps,
	output twp_pkg::gain_arr_t   gains_nxt,
	output twp_pkg::gain_t       best_nxt,
	output twp_pkg::scale_req_t  sreq,
	output twp_pkg::search_stat_t stat
);
	import twp_pkg::*;

	typedef logic signed [GAIN_W+1:0] wide_t;

	gain_arr_t gains_q;
	gain_t     best_q;
	gidx_t     idx_q;
	phase_t    phase_q;
	logic      started_q;

	gain_arr_t gains_n;
	gain_t     best_n;
	gidx_t     idx_n;
	phase_t    phase_n;
	logic      started_n;
	gidx_t     idx_inc;
	gidx_t     k;
	gain_t     g;
	step_t     s;
	gain_t     g_plus;
	gain_t     g_minus2;
	logic      better;
	logic      grow;

	// magnitude, most negative value saturates
	function automatic step_t mag(input gain_t v);
		logic [GAIN_W-1:0] neg;
		neg = -v;
		if (!v[GAIN_W-1])
			return v[STEP_W-1:0];
		else if (neg[GAIN_W-1])
			return '1;
		else
			return neg[STEP_W-1:0];
	endfunction

	function automatic gain_t sat(input wide_t v);
		if (v[GAIN_W+1:GAIN_W-1] == '0 || v[GAIN_W+1:GAIN_W-1] == '1)
			return v[GAIN_W-1:0];
		else if (v[GAIN_W+1])
			return {1'b1, {(GAIN_W-1){1'b0}}};
		else
			return {1'b0, {(GAIN_W-1){1'b1}}};
	endfunction

	assign k        = idx_q;
	assign g        = gains_q[k];
	assign s        = steps[k];
	assign g_plus   = sat(wide_t'(g) + wide_t'({1'b0, s}));
	assign g_minus2 = sat(wide_t'(g) - wide_t'({s, 1'b0}));
	assign better   = mag(err) < mag(best_q);
	assign idx_inc  = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;

	always_comb begin
		gains_n   = gains_q;
		best_n    = best_q;
		idx_n     = idx_q;
		phase_n   = phase_q;
		started_n = started_q;
		grow      = 1'b0;
		sreq.en   = 1'b0;
		if (!started_q) begin
			gains_n   = cfg_gain;
			best_n    = err;
			idx_n     = '0;
			phase_n   = PH_ADD;
			started_n = 1'b1;
		end else begin
			unique case (phase_q)
				PH_ADD: begin
					gains_n[k] = g_plus;
					phase_n    = PH_PLUS;
				end
				PH_PLUS, PH_MINUS: begin
					priority if (better) begin
						best_n  = err;
						grow    = 1'b1;
						sreq.en = 1'b1;
						idx_n   = idx_inc;
						phase_n = PH_ADD;
					end else if (phase_q == PH_PLUS) begin
						gains_n[k] = g_minus2;
						phase_n    = PH_MINUS;
					end else begin
						// neither direction helped: put the gain back
						gains_n[k] = g_plus;
						sreq.en    = 1'b1;
						idx_n      = idx_inc;
						phase_n    = PH_ADD;
					end
				end
				default: phase_n = PH_ADD;
			endcase
		end
		sreq.idx = k;
		// step times 9, or 11 when growing, plus rounding, by shift and add
		sreq.num = (num_t'(s) << 3) + num_t'(s) + (grow ? (num_t'(s) << 1) : '0)
			+ num_t'(ROUND_ADD);
	end

	assign gains_nxt = gains_n;
	assign best_nxt  = best_n;
	assign stat      = '{started: started_q, phase: phase_q, idx: idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q   <= '{default: '0};
			best_q    <= '0;
			idx_q     <= '0;
			phase_q   <= PH_ADD;
			started_q <= 1'b0;
		end else if (fire) begin
			gains_q   <= gains_n;
			best_q    <= best_n;
			idx_q     <= idx_n;
			phase_q   <= phase_n;
			started_q <= started_n;
		end
	end

endmodule

@@ src/twp_step_scale.sv @@
// divide-by-ten of the scaled step numerator with saturation to 31 bits
// depends on twp_pkg
module twp_step_scale (
	input  twp_pkg::num_t  num,
	output twp_pkg::step_t step
);
	import twp_pkg::*;

	localparam int SPLIT    = 17;
	localparam int Y_W      = NUM_W - 1;
	localparam int YH_W     = Y_W - SPLIT;
	localparam int V_W      = SPLIT + 2;
	localparam int RECIP_SH = 21;
	localparam int RECIP5   = ((1 << RECIP_SH) + 4) / 5;
	localparam int HI_MUL   = (1 << SPLIT) / 5;
	localparam int P_W      = 2 * V_W;

	logic [Y_W-1:0]    y;
	logic [YH_W-1:0]   yh;
	logic [SPLIT-1:0]  yl;
	logic [V_W-1:0]    v;
	logic [P_W-1:0]    prod_lo;
	logic [GAIN_W-1:0] prod_hi;
	logic [GAIN_W-1:0] q;

	// x/10 = (x>>1)/5; split so 2^17 = 5*26214 + 2 folds into the low part
	assign y       = num[NUM_W-1:1];
	assign yh      = y[Y_W-1:SPLIT];
	assign yl      = y[SPLIT-1:0];
	assign v       = V_W'({yh, 1'b0}) + V_W'(yl);
	assign prod_lo = P_W'(v) * P_W'(RECIP5);
	assign prod_hi = GAIN_W'(yh) * GAIN_W'(HI_MUL);
	assign q       = prod_hi + GAIN_W'(prod_lo[P_W-1:RECIP_SH]);
	assign step    = q[GAIN_W-1] ? '1 : q[STEP_W-1:0];

endmodule

@@ src/twiddle_pid_gain_tuner.sv @@
// top level of the twiddle gain tuner: config registers, pipeline, step store
// depends on twp_pkg, twp_search, twp_step_scale and the defines header
//
// Usage: write the starting gains, steps and tolerance on the config channel
// (index 0..6, always ready) while the block is idle. Each trial_error transfer
// on the input channel yields one result transfer carrying the gains for the
// next trial, the best error so far and the finished flag. The first item after
// reset loads gains and steps from the config registers.
// Path: an item passes the input register, the search update, the step
// division and the step sum compare into the output register, in that order.
// Throughput: one item per cycle sustained; every stage moves on its own, so
// inputs keep flowing while a result waits, until the pipeline fills.
// Stall: with out_ready low the result holds and upstream stages fill in turn;
// in_ready drops once all four stages are occupied.
// Reset: clears the pipeline, the search state and steps to zero and loads the
// config registers with their default values.
`include "twiddle_pid_gain_tuner_defines.svh"

module twiddle_pid_gain_tuner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  twp_pkg::gain_t                trial_error,
	output logic                          out_valid,
	input  logic                          out_ready,
	output twp_pkg::gain_t                gain_p,
	output twp_pkg::gain_t                gain_i,
	output twp_pkg::gain_t                gain_d,
	output twp_pkg::gain_t                best_error,
	output logic                          finished,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [twp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [twp_pkg::GAIN_W-1:0]    cfg_data
);
	import twp_pkg::*;

	gain_arr_t    cfg_gain_q;
	step_arr_t    cfg_step_q;
	step_t        tol_q;
	step_arr_t    steps_q;

	logic         v_s1, v_s2, v_s3;
	gain_t        err_s1;
	gain_arr_t    gains_s2, gains_s3;
	gain_t        best_s2, best_s3;
	scale_req_t   sreq_s2;

	logic         out_valid_q;
	gain_arr_t    out_gain_q;
	gain_t        out_best_q;
	logic         finished_q;

	logic         en1, en2, en3, en_out;
	logic         fire1, fire2, fire3;
	gain_arr_t    gains_nxt;
	gain_t        best_nxt;
	scale_req_t   sreq;
	search_stat_t stat;
	step_t        step_new;
	logic [STEP_W+1:0] step_sum;

	assign en_out = !out_valid_q || out_ready;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;
	assign fire1  = v_s1 && en2;
	assign fire2  = v_s2 && en3;
	assign fire3  = v_s3 && en_out;

	assign in_ready  = en1;
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_gain_q <= '{RST_GAIN_P, RST_GAIN_I, RST_GAIN_D};
			cfg_step_q <= '{RST_STEP_P, RST_STEP_I, RST_STEP_D};
			tol_q      <= RST_TOL;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GAIN_P: cfg_gain_q[0] <= cfg_data;
				CFG_GAIN_I: cfg_gain_q[1] <= cfg_data;
				CFG_GAIN_D: cfg_gain_q[2] <= cfg_data;
				CFG_STEP_P: cfg_step_q[0] <= cfg_data[STEP_W-1:0];
				CFG_STEP_I: cfg_step_q[1] <= cfg_data[STEP_W-1:0];
				CFG_STEP_D: cfg_step_q[2] <= cfg_data[STEP_W-1:0];
				CFG_TOL:    tol_q         <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	twp_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire1),
		.err       (err_s1),
		.cfg_gain  (cfg_gain_q),
		.steps     (steps_q),
		.gains_nxt (gains_nxt),
		.best_nxt  (best_nxt),
		.sreq      (sreq),
		.stat      (stat)
	);

	twp_step_scale u_step_scale (
		.num  (sreq_s2.num),
		.step (step_new)
	);

	// steps: loaded on the first item, rescaled one stage after the decision;
	// the next item always works on another index, so the late write is safe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '{default: '0};
		end else if (fire1 && !stat.started) begin
			steps_q <= cfg_step_q;
		end else if (fire2 && sreq_s2.en) begin
			steps_q[sreq_s2.idx] <= step_new;
		end
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= in_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
			if (en_out)
				out_valid_q <= v_s3;
		end
	end

	always_comb begin
		step_sum = '0;
		for (int i = 0; i < NUM_GAINS; i++)
			step_sum = step_sum + (STEP_W+2)'(steps_q[i]);
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (in_valid && en1)
			err_s1 <= trial_error;
		if (fire1) begin
			gains_s2 <= gains_nxt;
			best_s2  <= best_nxt;
			sreq_s2  <= sreq;
		end
		if (fire2) begin
			gains_s3 <= gains_s2;
			best_s3  <= best_s2;
		end
		if (fire3) begin
			out_gain_q <= gains_s3;
			out_best_q <= best_s3;
			finished_q <= step_sum < (STEP_W+2)'(tol_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign gain_p     = out_gain_q[0];
	assign gain_i     = out_gain_q[1];
	assign gain_d     = out_gain_q[2];
	assign best_error = out_best_q;
	assign finished   = finished_q;

	`TWP_ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, stat.idx <= IDX_LAST)
	`TWP_ASSERT_IMPL(a_scale_idx, clk, arst_n, v_s2 && sreq_s2.en, sreq_s2.idx != stat.idx)
	`TWP_ASSERT_NEXT(a_start_load, clk, arst_n, fire1, stat.started)
	`TWP_ASSERT_IMPL(a_out_started, clk, arst_n, out_valid_q, stat.started)

endmodule
